@@ hw/rtl/jlts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jlts_pkg: shared types and microcode for the last-two-survivors block
// Field widths, sequencer step addresses, control word layout and the
// read-only program that drives the datapath.
// ----------------------------------------------------------------------------
package jlts_pkg;

  localparam int unsigned FIELD_W        = 11;
  localparam int unsigned DEF_MAX_PEOPLE = 1024;
  localparam int unsigned STEP_W         = 4;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [STEP_W-1:0]  step_t;

  // step addresses
  localparam step_t S_IDLE  = step_t'(0);
  localparam step_t S_CHECK = step_t'(1);
  localparam step_t S_FWD   = step_t'(2);
  localparam step_t S_DIV   = step_t'(3);
  localparam step_t S_NEXT  = step_t'(4);
  localparam step_t S_BINIT = step_t'(5);
  localparam step_t S_BUPD  = step_t'(6);
  localparam step_t S_BWAIT = step_t'(7);
  localparam step_t S_SMALL = step_t'(8);
  localparam step_t S_OUT   = step_t'(9);
  localparam step_t S_DONE  = step_t'(10);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_FWD,
    OP_DIV,
    OP_NEXT,
    OP_BINIT,
    OP_BUPD,
    OP_SMALL,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_SMALL,
    C_FWD_DONE,
    C_DIV_BUSY,
    C_BACK_DONE,
    C_OUT_BUSY
  } cond_t;

  // jump to target when cond holds, else fall through to the next step
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      S_IDLE:  w = '{op: OP_LOAD,  cond: C_NO_INPUT,  target: S_IDLE};
      S_CHECK: w = '{op: OP_NOP,   cond: C_SMALL,     target: S_SMALL};
      S_FWD:   w = '{op: OP_FWD,   cond: C_FWD_DONE,  target: S_BINIT};
      S_DIV:   w = '{op: OP_DIV,   cond: C_DIV_BUSY,  target: S_DIV};
      S_NEXT:  w = '{op: OP_NEXT,  cond: C_ALWAYS,    target: S_FWD};
      S_BINIT: w = '{op: OP_BINIT, cond: C_NEVER,     target: S_IDLE};
      S_BUPD:  w = '{op: OP_BUPD,  cond: C_BACK_DONE, target: S_OUT};
      S_BWAIT: w = '{op: OP_NOP,   cond: C_ALWAYS,    target: S_BUPD};
      S_SMALL: w = '{op: OP_SMALL, cond: C_ALWAYS,    target: S_OUT};
      S_OUT:   w = '{op: OP_EMIT,  cond: C_OUT_BUSY,  target: S_OUT};
      S_DONE:  w = '{op: OP_NOP,   cond: C_ALWAYS,    target: S_IDLE};
      default: w = '{op: OP_NOP,   cond: C_ALWAYS,    target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/jlts_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jlts_if: item channels of the last-two-survivors block
// Valid/ready channels for circle items in and survivor items out.
// ----------------------------------------------------------------------------
interface jlts_in_if import jlts_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t people_count;
  field_t step_count;

  modport source (output valid, output people_count, output step_count, input ready);
  modport sink   (input valid, input people_count, input step_count, output ready);
endinterface

interface jlts_out_if import jlts_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t lower_survivor;
  field_t higher_survivor;

  modport source (output valid, output lower_survivor, output higher_survivor, input ready);
  modport sink   (input valid, input lower_survivor, input higher_survivor, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/jlts_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jlts_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module jlts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/josephus_last_two_survivors.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// josephus_last_two_survivors: last two survivors of a Josephus circle
// Each item in_item carries a circle size N and a step K; one item on
// out_item returns the two survivors, smaller number first. N above
// MAX_PEOPLE is taken as MAX_PEOPLE; N of 0, 1, 2 give (0,0), (1,1), (1,2).
// A microcoded sequencer runs a forward pass that records the slot removed
// at each round in a RAM (slot = (slot + K - 1) mod size, on a restoring
// remainder unit, one bit a cycle), then a backward pass maps the two final
// slots back to person numbers, one RAM read per round.
// One item is worked at a time; in_item.ready is high only while the
// sequencer waits for work, once a result is loaded and the S_DONE step
// has passed.
// A finished result sits in the output register; if the receiver stalls,
// the next item is still taken and worked, and waits only at hand-over.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_item.valid; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module josephus_last_two_survivors import jlts_pkg::*; #(
  parameter int unsigned MAX_PEOPLE = DEF_MAX_PEOPLE
) (
  input  wire logic clk,
  input  wire logic rst_n,
  jlts_in_if.sink   in_item,
  jlts_out_if.source out_item
);

  localparam int unsigned PW  = $clog2(MAX_PEOPLE + 1);
  localparam int unsigned AW  = $clog2(MAX_PEOPLE);
  localparam int unsigned XW  = (PW > FIELD_W) ? PW : FIELD_W;
  localparam int unsigned DW  = XW + 1;
  localparam int unsigned CNW = $clog2(DW + 1);

  step_t  pc_r, pc_nxt;
  ucode_t cw;
  logic   jump;

  logic [PW-1:0]      n_r, n_nxt;
  field_t             k_r, k_nxt;
  logic [PW-1:0]      t_r, t_nxt;
  logic [PW-1:0]      r_r, r_nxt;
  logic [AW-1:0]      i_r, i_nxt;
  logic [PW-1:0]      a_r, a_nxt;
  logic [PW-1:0]      b_r, b_nxt;
  logic [DW-1:0]      dvd_r, dvd_nxt;
  logic [PW-1:0]      rem_r, rem_nxt;
  logic [CNW-1:0]     cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  field_t             lo_r, lo_nxt;
  field_t             hi_r, hi_nxt;

  logic [PW-1:0]      n_in;
  logic [PW:0]        trial;
  logic [PW:0]        trial_sub;
  logic [PW-1:0]      t_rd;
  logic               out_busy;
  logic               ram_we;

  assign cw       = ucode_rom(pc_r);
  assign out_busy = out_valid_r && !out_item.ready;

  assign in_item.ready        = (pc_r == S_IDLE);
  assign out_item.valid       = out_valid_r;
  assign out_item.lower_survivor  = lo_r;
  assign out_item.higher_survivor = hi_r;

  // clamp oversized circles
  assign n_in = (XW'(in_item.people_count) > XW'(MAX_PEOPLE)) ?
                PW'(MAX_PEOPLE) : PW'(in_item.people_count);

  assign trial     = {rem_r, dvd_r[DW-1]};
  assign trial_sub = trial - {1'b0, r_r};
  assign ram_we    = (cw.op == OP_FWD);

  jlts_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_PEOPLE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (i_r),
    .wdata (t_r),
    .raddr (i_r),
    .rdata (t_rd)
  );

  always_comb begin
    case (cw.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_INPUT:  jump = !in_item.valid;
      C_SMALL:     jump = (n_r <= PW'(2));
      C_FWD_DONE:  jump = (PW'(i_r) == n_r - PW'(3));
      C_DIV_BUSY:  jump = (cnt_r != CNW'(1));
      C_BACK_DONE: jump = (i_r == '0);
      C_OUT_BUSY:  jump = out_busy;
      default:     jump = 1'b1;
    endcase
    pc_nxt = jump ? cw.target : pc_r + step_t'(1);
  end

  always_comb begin
    n_nxt         = n_r;
    k_nxt         = k_r;
    t_nxt         = t_r;
    r_nxt         = r_r;
    i_nxt         = i_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    case (cw.op)
      OP_LOAD: begin
        if (in_item.valid) begin
          n_nxt = n_in;
          k_nxt = in_item.step_count;
          t_nxt = '0;
          i_nxt = '0;
          r_nxt = n_in - PW'(1);
        end
      end
      OP_FWD: begin
        // next slot = (slot + K - 1) mod size; K of 0 keeps slot 0
        dvd_nxt = (k_r == '0) ? '0 : DW'(t_r) + DW'(k_r) - DW'(1);
        rem_nxt = '0;
        cnt_nxt = CNW'(DW);
      end
      OP_DIV: begin
        rem_nxt = trial_sub[PW] ? trial[PW-1:0] : trial_sub[PW-1:0];
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r - CNW'(1);
      end
      OP_NEXT: begin
        t_nxt = rem_r;
        i_nxt = i_r + AW'(1);
        r_nxt = r_r - PW'(1);
      end
      OP_BINIT: begin
        a_nxt = PW'(1);
        b_nxt = PW'(2);
      end
      OP_BUPD: begin
        a_nxt = a_r + PW'(a_r > t_rd);
        b_nxt = b_r + PW'(b_r > t_rd);
        i_nxt = i_r - AW'(1);
      end
      OP_SMALL: begin
        a_nxt = (n_r == '0) ? '0 : PW'(1);
        b_nxt = n_r;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          lo_nxt        = FIELD_W'(a_r);
          hi_nxt        = FIELD_W'(b_r);
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    k_r   <= k_nxt;
    t_r   <= t_nxt;
    r_r   <= r_nxt;
    i_r   <= i_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
  end

endmodule
`default_nettype wire

@@ test/josephus_survivor_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// josephus_survivor_checker: survivor prediction and comparison
// Watches both item channels of the last-two-survivors block. Each circle
// item taken in is played out on a local copy of the circle to give the
// expected survivor pair; each survivor item handed out is compared field
// by field with the oldest pair still due.
// ----------------------------------------------------------------------------
module josephus_survivor_checker import jlts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  jlts_in_if   in_ch,
  jlts_out_if  out_ch,
  output int   pending,
  output int   fail_count
);

  typedef struct packed {
    field_t lower;
    field_t higher;
  } survivors_t;

  survivors_t  survivor_pairs_due [$];
  int          mismatch_total = 0;

  int unsigned seat [0:DEF_MAX_PEOPLE];
  int unsigned first_slot = 0;
  int unsigned end_slot   = 0;
  int unsigned aim_slot   = 0;

  // seats first_slot .. end_slot-1 hold the people still standing
  function automatic survivors_t play_out_circle(input field_t people, input field_t step);
    int unsigned n, k, mid, remain, i, a, b;
    survivors_t  pair;
    n = people;
    k = step;
    if (n == 0) begin
      first_slot = 1;
      end_slot   = 1;
      aim_slot   = 1;
      pair       = '{lower: '0, higher: '0};
      return pair;
    end
    if (n > DEF_MAX_PEOPLE) n = DEF_MAX_PEOPLE;
    for (i = 1; i <= n; i++) seat[i] = i;
    first_slot = 1;
    end_slot   = n + 1;
    aim_slot   = 1;
    while (end_slot - first_slot > 2) begin
      mid = (first_slot + end_slot) / 2;
      if (aim_slot < mid) begin
        for (i = aim_slot; i > first_slot; i--) seat[i] = seat[i-1];
        first_slot++;
      end else begin
        for (i = aim_slot; i + 1 < end_slot; i++) seat[i] = seat[i+1];
        end_slot--;
        aim_slot--;
      end
      remain = end_slot - first_slot;
      if (k > remain) aim_slot += (k - 1) % remain + 1;
      else aim_slot += k;
      if (aim_slot > end_slot - 1) aim_slot -= remain;
    end
    a = seat[first_slot];
    b = seat[end_slot - 1];
    pair.lower  = field_t'((a < b) ? a : b);
    pair.higher = field_t'((a < b) ? b : a);
    return pair;
  endfunction

  always @(posedge clk) begin
    survivors_t got;
    survivors_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{lower: out_ch.lower_survivor, higher: out_ch.higher_survivor};
        if (survivor_pairs_due.size() == 0) begin
          $error("survivor item with none due: %0d, %0d", got.lower, got.higher);
          mismatch_total++;
        end else begin
          want = survivor_pairs_due.pop_front();
          if (got.lower !== want.lower) begin
            $error("lower_survivor: expected %0d, got %0d", want.lower, got.lower);
            mismatch_total++;
          end
          if (got.higher !== want.higher) begin
            $error("higher_survivor: expected %0d, got %0d", want.higher, got.higher);
            mismatch_total++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        survivor_pairs_due.push_back(play_out_circle(in_ch.people_count, in_ch.step_count));
    end
    pending    <= survivor_pairs_due.size();
    fail_count <= mismatch_total;
  end

endmodule

@@ test/josephus_last_two_survivors_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// josephus_last_two_survivors_tb: testbench top for the survivor block
// Drives circle items (directed corners, then weighted random sizes and
// steps) with random idling on both channels, and gives the verdict from
// the checker's failure count. A watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module josephus_last_two_survivors_tb;
  import jlts_pkg::*;

  localparam int STALL_LIMIT = 100000;
  localparam int DIR_COUNT   = 19;
  localparam int DIR_PEOPLE [DIR_COUNT] = '{0, 1, 2, 3, 3, 4, 5, 7, 10, 6,
                                            1024, 1024, 2047, 1025, 64, 65, 13, 100, 41};
  localparam int DIR_STEP   [DIR_COUNT] = '{5, 1, 7, 1, 0, 0, 2, 3, 2047, 1024,
                                            1, 2047, 3, 0, 64, 1, 13, 7, 3};

  logic clk;
  logic rst_n;
  int   pending;
  int   fail_count;
  int   items_sent   = 0;
  int   results_seen = 0;
  int   stall_cycles = 0;

  jlts_in_if  in_ch ();
  jlts_out_if out_ch ();

  josephus_last_two_survivors uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  josephus_survivor_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver stalls, calm while results 40..69 arrive
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (results_seen >= 40 && results_seen < 70) begin
      out_ch.ready = 1'b1;
    end else begin
      out_ch.ready = ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) results_seen <= results_seen + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic offer_circle(input field_t people, input field_t step);
    @(negedge clk);
    while (!(items_sent >= 40 && items_sent < 70) && $urandom_range(99) < 12) begin
      in_ch.valid        = 1'b0;
      in_ch.people_count = field_t'($urandom);
      in_ch.step_count   = field_t'($urandom);
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.people_count = people;
    in_ch.step_count   = step;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  initial begin
    int     pick;
    field_t people;
    field_t step;
    in_ch.valid        = 1'b0;
    in_ch.people_count = '0;
    in_ch.step_count   = '0;
    rst_n              = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_COUNT; i++)
      offer_circle(field_t'(DIR_PEOPLE[i]), field_t'(DIR_STEP[i]));

    // mostly small circles and a few large ones
    repeat (81) begin
      pick = $urandom_range(99);
      if (pick < 4) people = field_t'($urandom_range(2047, 700));
      else if (pick < 20) people = field_t'($urandom_range(400, 65));
      else if (pick < 28) people = field_t'($urandom_range(2, 0));
      else people = field_t'($urandom_range(64, 3));
      if ($urandom_range(7) == 0) step = field_t'($urandom_range(2047, 0));
      else step = field_t'($urandom_range(70, 0));
      offer_circle(people, step);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/jlts_pkg.sv
hw/rtl/jlts_if.sv
hw/rtl/jlts_ram.sv
hw/rtl/josephus_last_two_survivors.sv
test/josephus_survivor_checker.sv
test/josephus_last_two_survivors_tb.sv
